// ----- rtl/tsst_pkg.sv -----
package tsst_pkg;

    localparam logic [1:0] OP_ADD_FRAME = 2'd0;
    localparam logic [1:0] OP_ADD_LINK  = 2'd1;
    localparam logic [1:0] OP_QUERY     = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_HANDLE_USED = 3'd1;
    localparam logic [2:0] ST_NO_FRAME   = 3'd2;
    localparam logic [2:0] ST_SLOT_TAKEN = 3'd3;
    localparam logic [2:0] ST_FULL       = 3'd4;
    localparam logic [2:0] ST_ZERO_LEN   = 3'd5;

    localparam int OPT_TX_BIT = 0;

    // one link table entry, without its frame index
    typedef struct packed {
        logic [7:0]  opts;
        logic        kind;
        logic [63:0] addr;
        logic [15:0] slot;
        logic [15:0] chan;
    } link_data_t;

    // result record handed to the output register
    typedef struct packed {
        logic [2:0]  status;
        logic        found;
        logic [15:0] best_slot;
        logic [15:0] best_channel;
        logic [15:0] best_handle;
        logic [7:0]  best_options;
        logic        best_kind;
        logic [63:0] best_address;
        logic [15:0] slots_to_next;
    } result_t;

endpackage

// ----- rtl/tsst_mod_unit.sv -----
// Unsigned 40-bit by 16-bit remainder, restoring, one quotient bit per cycle.
module tsst_mod_unit
    import tsst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [39:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] remainder
);

    logic [39:0] shift_reg, shift_next;
    logic [16:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;
    logic [17:0] diff;

    assign trial = {rem_reg[15:0], shift_reg[39]};
    assign diff  = {1'b0, trial} - {2'b00, divisor};

    always_comb begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            shift_next = dividend;
            rem_next   = '0;
            cnt_next   = 6'd0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            shift_next = {shift_reg[38:0], 1'b0};
            rem_next   = diff[17] ? trial : diff[16:0];
            cnt_next   = cnt_reg + 6'd1;
            if (cnt_reg == 6'd39) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg[15:0];

endmodule

// ----- rtl/tsch_slot_schedule_table_core.sv -----
// TSCH slot schedule table.
// Input channel s_*: one operation per transfer (add slotframe, add link,
// query by absolute slot number). Result channel m_*: exactly one result
// transfer per input transfer, in order.
// Steps from the input transfer to m_valid:
//   add slotframe: the frame table is in flip-flops.
//   add link:      the link memory is read one entry per cycle for the
//                  duplicate-slot scan.
//   query:         waits on a bit-serial remainder unit for each valid
//                  slotframe, then the link memory is scanned one entry
//                  per cycle.
// s_ready rises with m_valid. One operation is in flight at a time. The
// result sits in an output register; a new input is taken while it waits,
// and the next result waits for m_ready. Reset clears all valid marks;
// link contents stay undefined.
module tsch_slot_schedule_table_core
    import tsst_pkg::*;
#(
    parameter int MAX_FRAMES = 4,
    parameter int MAX_LINKS  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [15:0] s_frame_handle,
    input  logic [15:0] s_frame_length,
    input  logic [7:0]  s_options_in,
    input  logic        s_kind_in,
    input  logic [63:0] s_neighbor_address,
    input  logic [15:0] s_slot_in,
    input  logic [15:0] s_channel_in,
    input  logic [39:0] s_slot_number,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic        m_found,
    output logic [15:0] m_best_slot,
    output logic [15:0] m_best_channel,
    output logic [15:0] m_best_handle,
    output logic [7:0]  m_best_options,
    output logic        m_best_kind,
    output logic [63:0] m_best_address,
    output logic [15:0] m_slots_to_next
);

    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int LW = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int LCW = $clog2(MAX_LINKS + 1);
    localparam int FCW = $clog2(MAX_FRAMES + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_MODW  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_LAST  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    // frame table and link valid marks in flip-flops
    logic [MAX_FRAMES-1:0] fvalid_reg;
    logic [15:0]           fid_reg  [MAX_FRAMES];
    logic [15:0]           fsize_reg[MAX_FRAMES];
    logic [15:0]           fcur_reg [MAX_FRAMES];
    logic [MAX_LINKS-1:0]  lvalid_reg;

    // link memory: entry data plus frame index
    link_data_t      ldata_mem [MAX_LINKS];
    logic [FW-1:0]   lframe_mem[MAX_LINKS];
    link_data_t      rd_data;
    logic [FW-1:0]   rd_frame;
    logic [LW-1:0]   rd_addr;
    logic            wr_en;
    logic [LW-1:0]   wr_addr;

    // latched request
    logic [1:0]  op_reg;
    logic [15:0] handle_reg, length_reg, slot_reg, chan_reg;
    logic [7:0]  opts_reg;
    logic        kind_reg;
    logic [63:0] addr_reg;
    logic [39:0] asn_reg;

    logic [2:0]     state_reg;
    logic [LCW-1:0] idx_reg;      // read issue index
    logic [LW-1:0]  prev_reg;     // index of entry now on rd_data
    logic [FCW-1:0] fidx_reg;
    logic [FW-1:0]  hit_frame_reg;
    logic           dup_reg;
    logic           best_ok_reg;
    logic           best_tx_reg;
    logic [15:0]    best_hdl_reg;
    link_data_t     best_reg;
    logic [15:0]    earliest_reg;
    result_t        res_reg;
    result_t        res_next;
    logic           res_valid_reg;

    logic        mod_start, mod_done;
    logic [15:0] mod_rem;

    tsst_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mod_start),
        .dividend  (asn_reg),
        .divisor   (fsize_reg[fidx_reg[FW-1:0]]),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // frame lookup by handle
    logic          fhit;
    logic [FW-1:0] fhit_idx;
    logic          ffree;
    logic [FW-1:0] ffree_idx;
    always_comb begin
        fhit = 1'b0;
        fhit_idx = '0;
        ffree = 1'b0;
        ffree_idx = '0;
        for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
            if (fvalid_reg[i] && fid_reg[i] == handle_reg) begin
                fhit = 1'b1;
                fhit_idx = FW'(i);
            end
            if (!fvalid_reg[i]) begin
                ffree = 1'b1;
                ffree_idx = FW'(i);
            end
        end
    end

    // lowest free link entry
    logic          lfree;
    logic [LW-1:0] lfree_idx;
    always_comb begin
        lfree = 1'b0;
        lfree_idx = '0;
        for (int i = MAX_LINKS - 1; i >= 0; i--) begin
            if (!lvalid_reg[i]) begin
                lfree = 1'b1;
                lfree_idx = LW'(i);
            end
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    // one op in flight; output register holds its result
    logic s_fire;
    assign s_fire = s_valid && s_ready;
    // finish step proceeds once the output register is free or being drained
    logic fin_go;
    assign fin_go = (state_reg == S_FIN) && (!res_valid_reg || m_ready);

    assign rd_addr = idx_reg[LW-1:0];
    assign mod_start = (state_reg == S_MOD);
    assign wr_addr = lfree_idx;
    assign wr_en = fin_go && (op_reg == OP_ADD_LINK) && fhit
                   && !dup_reg && lfree;

    // link memory ports
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ldata_mem[wr_addr]  <= '{opts: opts_reg, kind: kind_reg, addr: addr_reg,
                                     slot: slot_reg, chan: chan_reg};
            lframe_mem[wr_addr] <= fhit_idx;
        end
        rd_data  <= ldata_mem[rd_addr];
        rd_frame <= lframe_mem[rd_addr];
    end

    // per-entry evaluation of the entry on rd_data
    logic        ent_ok;
    logic [15:0] ent_cur, ent_size;
    logic [16:0] ent_dist_w;
    logic [15:0] ent_dist;
    logic        ent_match, ent_tx, ent_take;
    assign ent_ok   = lvalid_reg[prev_reg] && fvalid_reg[rd_frame];
    assign ent_cur  = fcur_reg[rd_frame];
    assign ent_size = fsize_reg[rd_frame];
    assign ent_dist_w = (rd_data.slot > ent_cur)
                        ? {1'b0, rd_data.slot - ent_cur}
                        : {1'b0, ent_size} + {1'b0, rd_data.slot} - {1'b0, ent_cur};
    assign ent_dist  = ent_dist_w[15:0];
    assign ent_match = ent_ok && (rd_data.slot == ent_cur);
    assign ent_tx    = rd_data.opts[OPT_TX_BIT];
    assign ent_take  = ent_match && (!best_ok_reg || (ent_tx && !best_tx_reg)
                       || (ent_tx == best_tx_reg && fid_reg[rd_frame] < best_hdl_reg));

    logic scan_on;
    assign scan_on = (state_reg == S_SCAN && idx_reg != '0) || state_reg == S_LAST;

    // result record built for the finish step
    always_comb begin
        res_next = '0;
        unique case (op_reg)
            OP_ADD_FRAME: begin
                if (fhit) res_next.status = ST_HANDLE_USED;
                else if (length_reg == '0) res_next.status = ST_ZERO_LEN;
                else if (!ffree) res_next.status = ST_FULL;
            end
            OP_ADD_LINK: begin
                if (!fhit) res_next.status = ST_NO_FRAME;
                else if (dup_reg) res_next.status = ST_SLOT_TAKEN;
                else if (!lfree) res_next.status = ST_FULL;
            end
            OP_QUERY: begin
                res_next.slots_to_next = earliest_reg;
                if (best_ok_reg) begin
                    res_next.found        = 1'b1;
                    res_next.best_slot    = best_reg.slot;
                    res_next.best_channel = best_reg.chan;
                    res_next.best_handle  = best_hdl_reg;
                    res_next.best_options = best_reg.opts;
                    res_next.best_kind    = best_reg.kind;
                    res_next.best_address = best_reg.addr;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fvalid_reg    <= '0;
            lvalid_reg    <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= fin_go || (res_valid_reg && !m_ready);
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        idx_reg      <= '0;
                        fidx_reg     <= '0;
                        dup_reg      <= 1'b0;
                        best_ok_reg  <= 1'b0;
                        earliest_reg <= '0;
                        if (s_opcode == OP_QUERY)
                            state_reg <= S_MOD;
                        else if (s_opcode == OP_ADD_LINK)
                            state_reg <= S_SCAN;
                        else
                            state_reg <= S_FIN;
                    end
                end
                S_MOD: state_reg <= S_MODW;
                S_MODW: begin
                    if (fidx_reg == FCW'(MAX_FRAMES)) begin
                        state_reg <= S_SCAN;
                    end else if (!fvalid_reg[fidx_reg[FW-1:0]]) begin
                        fcur_reg[fidx_reg[FW-1:0]] <= '0;
                        fidx_reg <= fidx_reg + 1'b1;
                        state_reg <= (fidx_reg == FCW'(MAX_FRAMES - 1)) ? S_SCAN : S_MOD;
                    end else if (mod_done) begin
                        fcur_reg[fidx_reg[FW-1:0]] <= mod_rem;
                        fidx_reg <= fidx_reg + 1'b1;
                        state_reg <= (fidx_reg == FCW'(MAX_FRAMES - 1)) ? S_SCAN : S_MOD;
                    end
                end
                S_SCAN, S_LAST: begin
                    if (state_reg == S_SCAN) begin
                        prev_reg <= idx_reg[LW-1:0];
                        if (idx_reg == LCW'(MAX_LINKS - 1))
                            state_reg <= S_LAST;
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end else begin
                        state_reg <= S_FIN;
                    end
                    if (scan_on && ent_ok) begin
                        if (op_reg == OP_ADD_LINK) begin
                            if (rd_frame == hit_frame_reg && rd_data.slot == slot_reg)
                                dup_reg <= 1'b1;
                        end else begin
                            if (ent_take) begin
                                best_ok_reg  <= 1'b1;
                                best_tx_reg  <= ent_tx;
                                best_hdl_reg <= fid_reg[rd_frame];
                                best_reg     <= rd_data;
                            end
                            if (earliest_reg == '0 || ent_dist < earliest_reg)
                                earliest_reg <= ent_dist;
                        end
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        res_reg <= res_next;
                        if (op_reg == OP_ADD_FRAME && res_next.status == ST_OK) begin
                            fvalid_reg[ffree_idx] <= 1'b1;
                            fid_reg[ffree_idx]    <= handle_reg;
                            fsize_reg[ffree_idx]  <= length_reg;
                        end
                        if (wr_en)
                            lvalid_reg[lfree_idx] <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // request capture; frame index for link scans taken once frame table is stable
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg     <= s_opcode;
            handle_reg <= s_frame_handle;
            length_reg <= s_frame_length;
            opts_reg   <= s_options_in;
            kind_reg   <= s_kind_in;
            addr_reg   <= s_neighbor_address;
            slot_reg   <= s_slot_in;
            chan_reg   <= s_channel_in;
            asn_reg    <= s_slot_number;
        end
        hit_frame_reg <= fhit_idx;
    end

    assign m_valid         = res_valid_reg;
    assign m_status        = res_reg.status;
    assign m_found         = res_reg.found;
    assign m_best_slot     = res_reg.best_slot;
    assign m_best_channel  = res_reg.best_channel;
    assign m_best_handle   = res_reg.best_handle;
    assign m_best_options  = res_reg.best_options;
    assign m_best_kind     = res_reg.best_kind;
    assign m_best_address  = res_reg.best_address;
    assign m_slots_to_next = res_reg.slots_to_next;

    // a stalled result holds steady
    a_hold_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(res_reg)))
        else $error("result changed while stalled");
    // a result appears only from the finish step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == S_FIN) else $error("stray result");
    // query results report ok
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> m_status == ST_OK) else $error("found with error");

endmodule
